@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers used by rev_limit_flame_sequencer_core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression is never true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ src/rlfs_pkg.sv @@
// ----------------------------------------------------------------------------
// rlfs_pkg
// types and constants of the rev limit flame sequencer
// ----------------------------------------------------------------------------
package rlfs_pkg;

   // item kinds
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_SPARK = 1'b1;

   // flame modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_SAFE = 2'd1;
   localparam logic [1:0] MODE_AGGR = 2'd2;

   // csr indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAME_MODE = 2'd1;

   localparam logic [31:0] UPTIME_MIN_MS = 32'd30000;
   localparam logic [16:0] HEADROOM_RPM  = 17'd200;
   localparam logic [31:0] SAMPLE_MS     = 32'd10;

   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;
   localparam logic [31:0] LCG_INIT = 32'hF1AEC0DE;
   // seed after the first lcg step, kept one step ahead in state
   localparam logic [63:0] LCG_FIRST_W = 64'(LCG_INIT) * 64'(LCG_MUL) + 64'(LCG_ADD);
   localparam logic [31:0] LCG_FIRST   = LCG_FIRST_W[31:0];

   // safe set
   localparam logic [31:0] SAFE_DELAY_MS = 32'd1000;
   localparam logic [31:0] SAFE_CAP_MS   = 32'd3000;
   localparam logic [31:0] SAFE_COOL_MS  = 32'd2000;
   localparam logic [15:0] SAFE_VMIN_MV  = 16'd11500;
   localparam logic [12:0] SAFE_BASE_Q8  = 13'd1280;

   // aggressive set
   localparam logic [31:0] AGGR_DELAY_MS = 32'd1500;
   localparam logic [31:0] AGGR_CAP_MS   = 32'd5000;
   localparam logic [31:0] AGGR_COOL_MS  = 32'd5000;
   localparam logic [15:0] AGGR_VMIN_MV  = 16'd12000;
   localparam logic [12:0] AGGR_BASE_Q8  = 13'd3072;

   localparam logic [12:0] JIT_DIV   = 13'd510;
   localparam logic [12:0] JIT_ROUND = 13'd255;

   typedef struct packed {
      logic        func;
      logic [31:0] now_ms;
      logic [15:0] rpm;
      logic [15:0] overrev_rpm;
      logic        rev_limited;
      logic        spark_armed;
      logic        launch_on;
      logic        battery_derated;
      logic        battery_check_on;
      logic [15:0] battery_mv;
      logic        full_cut;
      logic [15:0] main_limit_rpm;
   } req_type;

   typedef struct packed {
      logic        fire;
      logic        active;
      logic [12:0] retard_q8;
      logic        in_cooldown;
      logic [15:0] cooldown_left_ms;
      logic [15:0] active_elapsed_ms;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic [12:0] retard;
      logic [31:0] engage_start;
      logic [31:0] active_start;
      logic [31:0] cooldown_deadline;
      logic [31:0] last_sample;
      logic [1:0]  phase;
      logic [31:0] lcg_next;
   } state_type;

endpackage

@@ src/rlfs_step.sv @@
// ----------------------------------------------------------------------------
// rlfs_step
// next state and result of one beat from the current state and config
// ----------------------------------------------------------------------------
module rlfs_step
   import rlfs_pkg::*;
(
   input  logic       enable,
   input  logic [1:0] flame_mode,
   input  state_type  st,
   input  req_type    item,
   output state_type  nxt,
   output rsp_type    res
);

   logic        aggr;
   logic [31:0] delay_ms;
   logic [31:0] cap_ms;
   logic [31:0] cool_ms;
   logic [15:0] vmin_mv;
   logic [12:0] base_q8;
   logic [7:0]  rnd;
   logic [10:0] jit_x;
   logic [12:0] jit_y;
   logic [3:0]  jit_q;
   logic [12:0] new_retard;
   logic        gate_fail;
   logic [31:0] now;
   logic [31:0] eng;
   logic [31:0] d_eng;
   logic [31:0] act_st;
   logic [31:0] d_act;
   logic [31:0] d_smp;
   logic [31:0] d_cd;
   logic [31:0] d_out;
   logic [31:0] rem;
   logic [31:0] el;
   logic        fire;

   assign aggr     = (flame_mode == MODE_AGGR);
   assign delay_ms = aggr ? AGGR_DELAY_MS : SAFE_DELAY_MS;
   assign cap_ms   = aggr ? AGGR_CAP_MS : SAFE_CAP_MS;
   assign cool_ms  = aggr ? AGGR_COOL_MS : SAFE_COOL_MS;
   assign vmin_mv  = aggr ? AGGR_VMIN_MV : SAFE_VMIN_MV;
   assign base_q8  = aggr ? AGGR_BASE_Q8 : SAFE_BASE_Q8;
   assign now      = item.now_ms;

   // jitter: x + floor((2x + 255) / 510), x = r * jitter
   assign rnd   = st.lcg_next[23:16];
   assign jit_x = aggr ? {rnd, 3'b000} : ({2'b00, rnd, 1'b0} + {3'b000, rnd});
   assign jit_y = {1'b0, jit_x, 1'b0} + JIT_ROUND;

   always_comb begin
      jit_q = '0;
      for (int k = 1; k <= 8; k++) begin
         if (jit_y >= 13'(k * 510)) begin
            jit_q = jit_q + 4'd1;
         end
      end
   end

   assign new_retard = base_q8 + {2'b00, jit_x} + {9'd0, jit_q};

   assign gate_fail = !enable || (flame_mode == MODE_OFF) || (now < UPTIME_MIN_MS) ||
                      !item.spark_armed || item.launch_on || item.battery_derated ||
                      (item.battery_check_on && (item.battery_mv < vmin_mv)) ||
                      d_cd[31] || item.full_cut || !item.rev_limited ||
                      !(({1'b0, item.rpm} + HEADROOM_RPM) < {1'b0, item.overrev_rpm});

   assign d_cd   = now - st.cooldown_deadline;
   assign eng    = (st.engage_start == '0) ? now : st.engage_start;
   assign d_eng  = now - eng;
   assign act_st = st.active ? st.active_start : now;
   assign d_act  = now - act_st;
   assign d_smp  = now - st.last_sample;

   always_comb begin
      nxt  = st;
      fire = 1'b1;
      if (item.func == FUNC_TICK) begin
         if (gate_fail) begin
            nxt.active       = 1'b0;
            nxt.retard       = '0;
            nxt.engage_start = '0;
            nxt.active_start = '0;
            nxt.phase        = '0;
         end else begin
            nxt.engage_start = eng;
            if (d_eng[31] || (d_eng < delay_ms)) begin
               nxt.active = 1'b0;
               nxt.retard = '0;
            end else begin
               if (!st.active) begin
                  nxt.phase = '0;
               end
               nxt.active       = 1'b1;
               nxt.active_start = act_st;
               if (!d_act[31] && (d_act >= cap_ms)) begin
                  nxt.cooldown_deadline = now + cool_ms;
                  nxt.active            = 1'b0;
                  nxt.retard            = '0;
                  nxt.engage_start      = '0;
                  nxt.active_start      = '0;
                  nxt.phase             = '0;
               end else if (!d_smp[31] && (d_smp >= SAMPLE_MS)) begin
                  nxt.retard      = new_retard;
                  nxt.last_sample = now;
                  nxt.lcg_next    = st.lcg_next * LCG_MUL + LCG_ADD;
               end
            end
         end
      end else if (st.active) begin
         nxt.phase = (st.phase == 2'd2) ? 2'd0 : st.phase + 2'd1;
         if (aggr) begin
            fire = (nxt.phase == 2'd0);
         end else begin
            fire = (nxt.phase != 2'd2);
         end
      end
   end

   assign rem   = nxt.cooldown_deadline - now;
   assign d_out = now - nxt.cooldown_deadline;
   assign el    = now - nxt.active_start;

   always_comb begin
      res.fire              = fire;
      res.active            = nxt.active;
      res.retard_q8         = nxt.active ? nxt.retard : '0;
      res.in_cooldown       = d_out[31];
      res.cooldown_left_ms  = (rem[31] || (rem == '0)) ? 16'd0 :
                              ((rem[31:16] != '0) ? 16'hFFFF : rem[15:0]);
      res.active_elapsed_ms = !nxt.active ? 16'd0 :
                              ((el[31:16] != '0) ? 16'hFFFF : el[15:0]);
   end

endmodule

@@ src/rev_limit_flame_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// rev_limit_flame_sequencer_core
// exhaust flame sequencer: gate chain, engage delay, duration cap, jittered
// retard and spark skip pattern, one result beat per request beat
// ----------------------------------------------------------------------------
//  channel  handshake            payload            direction
//  req      req_valid/req_stall  req_data           in
//  rsp      rsp_valid/rsp_stall  rsp_data           out
//  csr      csr_valid/csr_ready  csr_index/wdata    in
//
//  one beat per cycle sustained while rsp_stall is low; a beat passes from req to rsp
//  through the input register, then one pass of the step logic into the result register
//  reset clears the state to its power-up values and both registers to empty
//  rsp_stall holds the result register; the input register keeps taking a
//  beat until it is full too, then req_stall rises
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rev_limit_flame_sequencer_core
   import rlfs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [1:0]           csr_wdata
);

   logic       in_valid_ff;
   logic       in_valid_in;
   req_type    in_data_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   rsp_type    rsp_data_ff;
   logic       enable_ff;
   logic [1:0] mode_ff;
   state_type  state_ff;
   state_type  state_in;
   state_type  step_nxt;
   rsp_type    step_res;
   logic       advance;
   logic       req_take;
   logic       csr_hit;

   rlfs_step u_step (
      .enable     (enable_ff),
      .flame_mode (mode_ff),
      .st         (state_ff),
      .item       (in_data_ff),
      .nxt        (step_nxt),
      .res        (step_res)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_take     = req_valid && !req_stall;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign csr_ready    = 1'b1;
   assign csr_hit      = csr_valid && ((csr_index == CSR_ENABLE) ||
                                       (csr_index == CSR_FLAME_MODE));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   // config write clears the run and the cooldown deadline
   always_comb begin
      state_in = state_ff;
      if (csr_hit) begin
         state_in.active            = 1'b0;
         state_in.retard            = '0;
         state_in.engage_start      = '0;
         state_in.active_start      = '0;
         state_in.phase             = '0;
         state_in.cooldown_deadline = '0;
      end else if (advance) begin
         state_in = step_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         enable_ff                   <= 1'b0;
         mode_ff                     <= MODE_OFF;
         state_ff.active             <= 1'b0;
         state_ff.retard             <= '0;
         state_ff.engage_start       <= '0;
         state_ff.active_start       <= '0;
         state_ff.cooldown_deadline  <= '0;
         state_ff.last_sample        <= '0;
         state_ff.phase              <= '0;
         state_ff.lcg_next           <= LCG_FIRST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         if (csr_valid && (csr_index == CSR_ENABLE)) begin
            enable_ff <= csr_wdata[0];
         end
         if (csr_valid && (csr_index == CSR_FLAME_MODE)) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_res;
      end
   end

   `ASSERT_NEVER(a_phase_range, clock, reset, state_ff.phase == 2'd3)
   `ASSERT_NEVER(a_retard_range, clock, reset, state_ff.retard > 13'd5120)
   `ASSERT_PROP(a_idle_retard, clock, reset, rsp_valid_ff && !rsp_data_ff.active |-> rsp_data_ff.retard_q8 == '0)
   `ASSERT_PROP(a_idle_elapsed, clock, reset, rsp_valid_ff && !rsp_data_ff.active |-> rsp_data_ff.active_elapsed_ms == '0)
   `ASSERT_PROP(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))

endmodule
